// ===== sv/mwmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mwmp_pkg: shared definitions for the monotone path block
// Holds the default column count, the field widths, the controller state
// type and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mwmp_pkg;

    localparam int MWMP_COLS = 1024;

    localparam int ROW_W = 16;
    localparam int COL_W = 10;
    localparam int WGT_W = 16;
    localparam int SUM_W = 32;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_ADD,
        S_UPDATE,
        S_EMIT
    } t_state;

    // Commands issued by the controller, at most one per cycle.
    typedef struct packed {
        logic clr;
        logic load;
        logic q_step;
        logic add;
        logic u_step;
        logic emit;
    } t_cmd;

    // Status reported back by the datapath.
    typedef struct packed {
        logic clr_done;
        logic q_done;
        logic u_done;
        logic err;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/mwmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mwmp_ctrl: sequencing state machine
// Walks each point through the tree query, sum, tree update and result load,
// a rejected one straight to the load; sweeps clear after reset and last beats.
// ----------------------------------------------------------------------------
module mwmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mwmp_pkg::t_sts i_sts,
    output mwmp_pkg::t_cmd o_cmd,
    output logic           o_stall
);
    import mwmp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_QUERY;
                end
            end
            S_QUERY: begin
                if (i_sts.err) begin
                    n_state = S_EMIT;
                end else if (i_sts.q_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.u_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_QUERY: begin
                o_cmd.q_step = !i_sts.err;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.u_step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/mwmp_dp.sv =====
// ----------------------------------------------------------------------------
// mwmp_dp: datapath with the prefix-maximum tree memory
// Column bests are kept as a binary indexed tree of running maxima, so a
// prefix maximum and an update each touch about log2 of the depth nodes.
// ----------------------------------------------------------------------------
module mwmp_dp #(
    parameter int COLS = mwmp_pkg::MWMP_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mwmp_pkg::t_cmd               i_cmd,
    output mwmp_pkg::t_sts               o_sts,
    input  logic [mwmp_pkg::ROW_W-1:0]   i_row,
    input  logic [mwmp_pkg::COL_W-1:0]   i_column,
    input  logic [mwmp_pkg::WGT_W-1:0]   i_passengers,
    input  logic                         i_last,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [mwmp_pkg::SUM_W-1:0]   o_best_ending_here,
    output logic [mwmp_pkg::SUM_W-1:0]   o_best_overall,
    output logic                         o_order_error,
    output logic                         o_final_res
);
    import mwmp_pkg::*;

    // Columns beyond the reach of the column field never need storage.
    localparam int DEPTH = (COLS < (1 << COL_W)) ? COLS : (1 << COL_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = AW + 2;

    logic [SUM_W-1:0] mem [DEPTH];

    logic [ROW_W-1:0] r_row_prev, n_row_prev;
    logic [COL_W-1:0] r_col_prev, n_col_prev;
    logic             r_seen, n_seen;
    logic [SUM_W-1:0] r_overall, n_overall;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [WGT_W-1:0] r_w, n_w;
    logic             r_last, n_last;
    logic             r_err, n_err;
    logic [SUM_W-1:0] r_best, n_best;
    logic [SUM_W-1:0] r_here, n_here;
    logic [IW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_widx, n_widx;
    logic             r_pend, n_pend;
    logic [SUM_W-1:0] r_rd;
    logic             r_ovld, n_ovld;
    logic [SUM_W-1:0] r_o_here, n_o_here;
    logic [SUM_W-1:0] r_o_overall, n_o_overall;
    logic             r_o_err, n_o_err;
    logic             r_o_last, n_o_last;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [SUM_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;

    logic [IW-1:0]    idx_m1;
    logic [IW-1:0]    lowbit;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_sat;
    logic             in_err;

    assign idx_m1  = r_idx - IW'(1);
    assign lowbit  = r_idx & (~r_idx + IW'(1));
    assign sum_ext = {1'b0, r_best} + (SUM_W+1)'(r_w);
    assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

    // A point must lie strictly after the last accepted one in row-major order.
    assign in_err = (32'(i_column) >= 32'(COLS)) ||
                    (r_seen && ((i_row < r_row_prev) ||
                                ((i_row == r_row_prev) && (i_column <= r_col_prev))));

    always_comb begin
        n_row_prev  = r_row_prev;
        n_col_prev  = r_col_prev;
        n_seen      = r_seen;
        n_overall   = r_overall;
        n_row       = r_row;
        n_col       = r_col;
        n_w         = r_w;
        n_last      = r_last;
        n_err       = r_err;
        n_best      = r_best;
        n_here      = r_here;
        n_idx       = r_idx;
        n_widx      = r_widx;
        n_pend      = r_pend;
        n_ovld      = r_ovld;
        n_o_here    = r_o_here;
        n_o_overall = r_o_overall;
        n_o_err     = r_o_err;
        n_o_last    = r_o_last;
        we          = 1'b0;
        waddr       = r_idx[AW-1:0];
        wdata       = '0;
        re          = 1'b0;
        raddr       = idx_m1[AW-1:0];

        if (i_cmd.clr) begin
            we    = 1'b1;
            n_idx = r_idx + IW'(1);
        end

        if (i_cmd.load) begin
            n_row  = i_row;
            n_col  = i_column;
            n_w    = i_passengers;
            n_last = i_last;
            n_err  = in_err;
            n_best = '0;
            n_here = '0;
            n_idx  = IW'(i_column) + IW'(1);
            n_pend = 1'b0;
        end

        // Query walks down the tree, stripping the lowest set bit each step.
        if (i_cmd.q_step) begin
            if (r_pend && (r_rd > r_best)) begin
                n_best = r_rd;
            end
            if (r_idx != '0) begin
                re     = 1'b1;
                n_idx  = r_idx & idx_m1;
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
        end

        if (i_cmd.add) begin
            n_here     = sum_sat;
            n_idx      = IW'(r_col) + IW'(1);
            n_pend     = 1'b0;
            n_row_prev = r_row;
            n_col_prev = r_col;
            n_seen     = 1'b1;
            if (sum_sat > r_overall) begin
                n_overall = sum_sat;
            end
        end

        // Update walks up the tree; each node read last cycle is written back
        // with the new value folded in while the next node is read.
        if (i_cmd.u_step) begin
            if (r_pend) begin
                we    = 1'b1;
                waddr = r_widx;
                wdata = (r_rd > r_here) ? r_rd : r_here;
            end
            if (r_idx <= IW'(DEPTH)) begin
                re     = 1'b1;
                n_widx = idx_m1[AW-1:0];
                n_idx  = r_idx + lowbit;
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
        end

        if (i_cmd.emit) begin
            n_ovld      = 1'b1;
            n_o_here    = r_here;
            n_o_overall = r_overall;
            n_o_err     = r_err;
            n_o_last    = r_last;
            if (r_last) begin
                n_overall  = '0;
                n_seen     = 1'b0;
                n_row_prev = '0;
                n_col_prev = '0;
                n_idx      = '0;
            end
        end else if (!i_stall) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_prev <= '0;
            r_col_prev <= '0;
            r_seen     <= 1'b0;
            r_overall  <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_row_prev <= n_row_prev;
            r_col_prev <= n_col_prev;
            r_seen     <= n_seen;
            r_overall  <= n_overall;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_ovld     <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_w         <= n_w;
        r_last      <= n_last;
        r_err       <= n_err;
        r_best      <= n_best;
        r_here      <= n_here;
        r_widx      <= n_widx;
        r_o_here    <= n_o_here;
        r_o_overall <= n_o_overall;
        r_o_err     <= n_o_err;
        r_o_last    <= n_o_last;
    end

    assign o_sts.clr_done = (r_idx == IW'(DEPTH - 1));
    assign o_sts.q_done   = (r_idx == '0) && !r_pend;
    assign o_sts.u_done   = (r_idx > IW'(DEPTH)) && !r_pend;
    assign o_sts.err      = r_err;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_ovld || !i_stall;

    assign o_valid            = r_ovld;
    assign o_best_ending_here = r_o_here;
    assign o_best_overall     = r_o_overall;
    assign o_order_error      = r_o_err;
    assign o_final_res        = r_o_last;

endmodule

// ===== sv/max_weight_monotone_path_dp.sv =====
// ----------------------------------------------------------------------------
// max_weight_monotone_path_dp: best right-or-down path sum over grid points
// Points arrive in row-major order; each beat returns the best sum ending at
// that point and the best sum seen so far in the current problem.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one point per beat (row, column, weight,
// last) on i_valid with o_stall as back pressure; the output channel carries
// one result per beat on o_valid with i_stall from the receiver.
// Each accepted point passes through a load, query steps down the tree, an
// add, update steps up the tree and a result load, the tree being walked one
// node a cycle through the single read port of the tree memory.
// An out-of-order or out-of-range point skips the tree walk and the add.
// After reset, and after the result of a beat marked last has been loaded,
// the tree memory is swept to zero at one entry per cycle, all min(COLS, 1024)
// entries of it, while o_stall stays high.
// A finished result waits in the output register while the receiver stalls;
// the block meanwhile accepts the next point and computes it. It stalls its
// input while it works on a point or sweeps the tree, and also when a second
// result would have nowhere to go.
// ----------------------------------------------------------------------------
module max_weight_monotone_path_dp #(
    parameter int COLS = mwmp_pkg::MWMP_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mwmp_pkg::ROW_W-1:0]   i_row,
    input  logic [mwmp_pkg::COL_W-1:0]   i_column,
    input  logic [mwmp_pkg::WGT_W-1:0]   i_passengers,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [mwmp_pkg::SUM_W-1:0]   o_best_ending_here,
    output logic [mwmp_pkg::SUM_W-1:0]   o_best_overall,
    output logic                         o_order_error,
    output logic                         o_final_res
);
    import mwmp_pkg::*;

    // Commands flow from the sequencer to the datapath, status flows back.
    t_cmd cmd;
    t_sts sts;

    mwmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // The datapath owns the tree memory, the order check and the result
    // register that decouples the two channels.
    mwmp_dp #(
        .COLS (COLS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_row              (i_row),
        .i_column           (i_column),
        .i_passengers       (i_passengers),
        .i_last             (i_last),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_best_ending_here (o_best_ending_here),
        .o_best_overall     (o_best_overall),
        .o_order_error      (o_order_error),
        .o_final_res        (o_final_res)
    );

endmodule

// ===== tb/mwmp_path_checker.sv =====
// ----------------------------------------------------------------------------
// mwmp_path_checker: result checker for the monotone path block
// Watches both channels, keeps its own copy of the column bests, predicts
// the result of every accepted point and compares it with the result beats.
// ----------------------------------------------------------------------------
module mwmp_path_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [mwmp_pkg::ROW_W-1:0]   i_row,
    input  logic [mwmp_pkg::COL_W-1:0]   i_column,
    input  logic [mwmp_pkg::WGT_W-1:0]   i_passengers,
    input  logic                         i_last,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [mwmp_pkg::SUM_W-1:0]   i_best_ending_here,
    input  logic [mwmp_pkg::SUM_W-1:0]   i_best_overall,
    input  logic                         i_order_error,
    input  logic                         i_final_res,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mwmp_pkg::*;

    typedef struct {
        logic [SUM_W-1:0] here;
        logic [SUM_W-1:0] overall;
        logic             order_err;
        logic             final_res;
    } t_path_result;

    logic [SUM_W-1:0] col_best [MWMP_COLS];
    logic [SUM_W-1:0] top_best;
    logic [ROW_W-1:0] taken_row;
    logic [COL_W-1:0] taken_col;
    logic             any_taken;

    t_path_result pending_results [$];
    int           mismatches = 0;

    function automatic void clear_path();
        foreach (col_best[i]) begin
            col_best[i] = '0;
        end
        top_best  = '0;
        taken_row = '0;
        taken_col = '0;
        any_taken = 1'b0;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic t_path_result path_step(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col,
                                               input logic [WGT_W-1:0] wgt,
                                               input logic             fin);
        t_path_result     res;
        logic [SUM_W-1:0] best;
        logic             rejected;
        rejected = (int'(col) >= MWMP_COLS) ||
                   (any_taken && (row < taken_row ||
                                  (row == taken_row && col <= taken_col)));
        res.here = '0;
        if (!rejected) begin
            best = '0;
            for (int i = 0; i <= int'(col); i++) begin
                if (col_best[i] > best) begin
                    best = col_best[i];
                end
            end
            res.here      = sat_sum(best, SUM_W'(wgt));
            col_best[col] = res.here;
            if (res.here > top_best) begin
                top_best = res.here;
            end
            taken_row = row;
            taken_col = col;
            any_taken = 1'b1;
        end
        res.overall   = top_best;
        res.order_err = rejected;
        res.final_res = fin;
        // The state is wiped after a last point, even a rejected one.
        if (fin) begin
            clear_path();
        end
        return res;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [SUM_W-1:0] want,
                                        input logic [SUM_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_path_result want;
        if (!i_rst_n) begin
            clear_path();
            pending_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(path_step(i_row, i_column, i_passengers, i_last));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat arrived with no point waiting for it");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("best_ending_here", want.here, i_best_ending_here);
                    check_field("best_overall", want.overall, i_best_overall);
                    check_field("order_error", SUM_W'(want.order_err),
                                SUM_W'(i_order_error));
                    check_field("final_res", SUM_W'(want.final_res), SUM_W'(i_final_res));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the monotone path block
// Sends a directed set of points and random problems of mostly well-ordered
// points, first with no gaps or back pressure and then with random ones;
// a checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mwmp_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_BEATS = 450;
    localparam int QUIET_BEATS  = 150;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [mwmp_pkg::ROW_W-1:0]     i_row = '0;
    logic [mwmp_pkg::COL_W-1:0]     i_column = '0;
    logic [mwmp_pkg::WGT_W-1:0]     i_passengers = '0;
    logic                           i_last = 1'b0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [mwmp_pkg::SUM_W-1:0]     o_best_ending_here;
    logic [mwmp_pkg::SUM_W-1:0]     o_best_overall;
    logic                           o_order_error;
    logic                           o_final_res;

    int fail_count;
    int pending;

    // When set, the sender leaves random gaps and the receiver stalls at random.
    logic idling = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    max_weight_monotone_path_dp dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_row              (i_row),
        .i_column           (i_column),
        .i_passengers       (i_passengers),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_best_ending_here (o_best_ending_here),
        .o_best_overall     (o_best_overall),
        .o_order_error      (o_order_error),
        .o_final_res        (o_final_res)
    );

    mwmp_path_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_row              (i_row),
        .i_column           (i_column),
        .i_passengers       (i_passengers),
        .i_last             (i_last),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_best_ending_here (o_best_ending_here),
        .i_best_overall     (o_best_overall),
        .i_order_error      (o_order_error),
        .i_final_res        (o_final_res),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // The receiver stalls on its own schedule, independent of the sender.
    always @(posedge i_clk) begin
        i_stall <= idling && ($urandom_range(99) < IDLE_PCT);
    end

    // Drives one point and returns at the edge where the beat is taken.
    // With no gap the valid simply stays high while the fields change.
    task automatic send_point(input logic [mwmp_pkg::ROW_W-1:0] row,
                              input logic [mwmp_pkg::COL_W-1:0] col,
                              input logic [mwmp_pkg::WGT_W-1:0] wgt,
                              input logic                       fin);
        while (idling && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_row        <= row;
        i_column     <= col;
        i_passengers <= wgt;
        i_last       <= fin;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Weights lean toward the extremes now and then.
    function automatic logic [mwmp_pkg::WGT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return WGT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // A fresh column is usually near the left edge, so that later rows
    // often land left of earlier points and the prefix maximum matters.
    function automatic logic [mwmp_pkg::COL_W-1:0] pick_column();
        return COL_W'(($urandom_range(2) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 63));
    endfunction

    initial begin
        int                         sent;
        int                         npts;
        int                         span;
        int                         wait_cycles;
        logic [mwmp_pkg::ROW_W-1:0] r;
        logic [mwmp_pkg::COL_W-1:0] c;
        logic [mwmp_pkg::ROW_W-1:0] prev_r;
        logic [mwmp_pkg::COL_W-1:0] prev_c;
        logic                       have_prev;
        logic                       in_order;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first problem starts with a zero-weight point
        // at the origin, repeats it, spans the corner columns, and throws in
        // each kind of out-of-order point: an earlier row, the very same
        // point, and a smaller column on the same row. It ends on an
        // accepted last point.
        send_point(16'd0,     10'd0,    16'd0,     1'b0);
        send_point(16'd0,     10'd0,    16'd5,     1'b0);
        send_point(16'd0,     10'd1023, 16'hFFFF,  1'b0);
        send_point(16'd1,     10'd0,    16'd1,     1'b0);
        send_point(16'd1,     10'd1023, 16'hFFFF,  1'b0);
        send_point(16'd0,     10'd5,    16'd7,     1'b0);
        send_point(16'd1,     10'd1023, 16'd3,     1'b0);
        send_point(16'd1,     10'd500,  16'd3,     1'b0);
        send_point(16'hFFFF,  10'd512,  16'hFFFF,  1'b0);
        send_point(16'hFFFF,  10'd1023, 16'd0,     1'b1);
        // After the clear, the corner point is accepted again from an empty
        // store, and a rejected last point still clears everything.
        send_point(16'hFFFF,  10'd1023, 16'd100,   1'b0);
        send_point(16'd0,     10'd0,    16'd1,     1'b1);
        send_point(16'd0,     10'd0,    16'd1,     1'b1);
        // Alternating bit patterns on every field, ending on a rejected last.
        send_point(16'h5555,  10'h2AA,  16'hAAAA,  1'b0);
        send_point(16'hAAAA,  10'h155,  16'h5555,  1'b0);
        send_point(16'hAAAA,  10'h155,  16'd0,     1'b1);

        // Random problems. Most points follow the previous accepted one in
        // row-major order; the rest repeat it or step back. The last point
        // of each problem carries the last flag whether it is in order or not.
        // The first stretch goes out with neither side idling.
        idling <= 1'b0;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            if (sent >= QUIET_BEATS) begin
                idling <= 1'b1;
            end
            npts      = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 30);
            if (npts > RANDOM_BEATS - sent) begin
                npts = RANDOM_BEATS - sent;
            end
            have_prev = 1'b0;
            prev_r    = '0;
            prev_c    = '0;
            for (int k = 0; k < npts; k++) begin
                in_order = 1'b1;
                if (!have_prev) begin
                    r = ROW_W'($urandom_range(1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 15));
                    c = pick_column();
                end else if ($urandom_range(99) < 85 &&
                             !(prev_r == 16'hFFFF && prev_c == 10'h3FF)) begin
                    if (prev_c != 10'h3FF && (prev_r == 16'hFFFF || $urandom_range(1))) begin
                        // Same row, further right: mostly a short step.
                        span = 1023 - int'(prev_c);
                        r    = prev_r;
                        c    = prev_c + COL_W'($urandom_range(1,
                                   ($urandom_range(3) == 0 || span < 16) ? span : 16));
                    end else begin
                        // A later row: usually the next few, sometimes a big jump.
                        span = 65535 - int'(prev_r);
                        r    = prev_r + ROW_W'(($urandom_range(7) == 0 || span < 3)
                                               ? $urandom_range(1, span)
                                               : $urandom_range(1, 3));
                        c    = pick_column();
                    end
                end else begin
                    in_order = 1'b0;
                    case ($urandom_range(2))
                        0: begin
                            r = prev_r;
                            c = prev_c;
                        end
                        1: begin
                            r = prev_r;
                            c = COL_W'($urandom_range(0, int'(prev_c)));
                        end
                        default: begin
                            r = (prev_r == 0) ? prev_r
                                              : ROW_W'($urandom_range(0, int'(prev_r) - 1));
                            c = (prev_r == 0) ? prev_c : COL_W'($urandom_range(0, 1023));
                        end
                    endcase
                end
                if (in_order) begin
                    prev_r    = r;
                    prev_c    = c;
                    have_prev = 1'b1;
                end
                send_point(r, c, pick_weight(), k == npts - 1);
                sent++;
            end
        end
        i_valid <= 1'b0;

        // Drain what is still in flight, then give the block a few more
        // cycles in case it emits something nobody asked for.
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run (every point walked through
    // the tree, plus a clearing sweep after every last point).
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
